@@ rtl/core/wtk_pkg.sv @@
// Package for the weighted top-k upsert table.
// Holds the item and entry types, the cell operation codes, the controller
// states and the weight function. No dependencies.
`default_nettype none

package wtk_pkg;

   localparam int TOP_COUNT_DEF = 32;
   localparam int KEY_W         = 64;
   localparam int VAL_W         = 64;
   localparam int RANK_W        = 5;
   // 7*stake + 3000*score stays below 2^77.
   localparam int WEIGHT_W      = 77;

   localparam logic [WEIGHT_W-1:0] STAKE_FACTOR = WEIGHT_W'(7);
   localparam logic [WEIGHT_W-1:0] SCORE_FACTOR = WEIGHT_W'(3000);
   localparam logic [VAL_W-1:0]    STAKE_SEED   = VAL_W'(64'd1000000000);
   localparam logic [VAL_W-1:0]    SCORE_SEED   = VAL_W'(64'd1000);

   localparam logic REQ_UPSERT = 1'b0;
   localparam logic REQ_LIST   = 1'b1;

   typedef struct packed {
      logic             req_type;
      logic [KEY_W-1:0] address_key;
      logic [VAL_W-1:0] stake;
      logic [VAL_W-1:0] work_score;
   } req_item_type;

   typedef struct packed {
      logic [RANK_W-1:0] rank;
      logic [KEY_W-1:0]  entry_key;
      logic [VAL_W-1:0]  entry_stake;
      logic [VAL_W-1:0]  entry_score;
      logic              last;
   } rsp_item_type;

   typedef struct packed {
      logic                valid;
      logic [WEIGHT_W-1:0] weight;
      logic [KEY_W-1:0]    key;
      logic [VAL_W-1:0]    stake;
      logic [VAL_W-1:0]    score;
   } entry_type;

   typedef enum logic [2:0] {
      OP_HOLD,
      OP_LOAD,
      OP_INSERT,
      OP_PAIR_LEFT,
      OP_PAIR_RIGHT,
      OP_SHIFT,
      OP_DROP
   } cell_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SORT,
      ST_DROP,
      ST_LIST
   } state_type;

   function automatic logic [WEIGHT_W-1:0] weight_of(input logic [VAL_W-1:0] stake,
                                                     input logic [VAL_W-1:0] score);
      weight_of = WEIGHT_W'(stake) * STAKE_FACTOR + WEIGHT_W'(score) * SCORE_FACTOR;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/wtk_cell.sv @@
// One cell of the ranking chain: holds a single table entry and its weight.
// Depends on wtk_pkg for the entry type, the operation codes and weight_of.
`default_nettype none

module wtk_cell #(
   parameter int SEED_INDEX = 0,
   parameter bit SEED_VALID = 1'b1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  wtk_pkg::cell_op_type op,
   input  wtk_pkg::entry_type   new_entry,
   input  wtk_pkg::entry_type   left_entry,
   input  wtk_pkg::entry_type   right_entry,
   input  logic                 right_gt,
   output wtk_pkg::entry_type   entry,
   output logic                 gt,
   output logic                 hit
);
   import wtk_pkg::*;

   localparam logic [VAL_W-1:0] SEED_NUM = VAL_W'(SEED_INDEX + 1);

   entry_type entry_ff;
   entry_type entry_in;

   // This entry belongs ahead of its left neighbor. Strict compare keeps the
   // ranking stable, and an empty cell always sorts last.
   assign gt  = entry_ff.valid && (!left_entry.valid || (entry_ff.weight > left_entry.weight));
   assign hit = entry_ff.valid && (entry_ff.key == new_entry.key);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      case (op)
         OP_HOLD: entry_in = entry_ff;
         OP_LOAD: begin
            if (hit) begin
               entry_in = new_entry;
            end
         end
         OP_INSERT: entry_in = new_entry;
         OP_PAIR_LEFT: begin
            if (right_gt) begin
               entry_in = right_entry;
            end
         end
         OP_PAIR_RIGHT: begin
            if (gt) begin
               entry_in = left_entry;
            end
         end
         OP_SHIFT: entry_in = right_entry;
         OP_DROP:  entry_in.valid = 1'b0;
         default:  entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid  <= SEED_VALID;
         entry_ff.key    <= SEED_NUM;
         entry_ff.stake  <= SEED_NUM * STAKE_SEED;
         entry_ff.score  <= SEED_NUM * SCORE_SEED;
         entry_ff.weight <= weight_of(SEED_NUM * STAKE_SEED, SEED_NUM * SCORE_SEED);
      end else begin
         entry_ff <= entry_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/weighted_top_k_upsert_table_top.sv @@
// Weighted top-k upsert table: a ring of TOP_COUNT+1 cells and its controller.
// Depends on wtk_pkg and wtk_cell.
// Update: weight on acceptance, write, TOP_COUNT+1 odd-even transposition passes over
//   the cell chain, drop of the last cell; the next request is taken after the drop.
// List: the chain rotates once, pausing while an item waits on the result side.
// Reset loads entry i with key i+1, stake 1e9*(i+1) and score 1000*(i+1).
`default_nettype none

module weighted_top_k_upsert_table_top #(
   parameter int TOP_COUNT = wtk_pkg::TOP_COUNT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  wtk_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output wtk_pkg::rsp_item_type rsp_item
);
   import wtk_pkg::*;

   localparam int CELL_COUNT = TOP_COUNT + 1;
   localparam int CNT_W      = $clog2(CELL_COUNT + 1);

   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(CELL_COUNT - 1);
   localparam logic [CNT_W-1:0] LAST_ITEM = CNT_W'(TOP_COUNT - 1);

   state_type state_ff, state_in;
   logic [CNT_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0] emit_ff, emit_in;
   entry_type        new_entry_ff, new_entry_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_item_type     rsp_item_ff, rsp_item_in;

   entry_type        cell_q [CELL_COUNT];
   cell_op_type      cell_op [CELL_COUNT];
   logic [CELL_COUNT-1:0] gt_vec;
   logic [CELL_COUNT-1:0] hit_vec;
   logic             any_hit;
   logic             accept;
   logic             step_ok;
   logic             emit;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;
   // Keys stay unique, so at most one cell can match.
   assign any_hit   = |hit_vec;

   // During a listing, an empty cell at the head passes without an item.
   assign emit    = (state_ff == ST_LIST) && cell_q[0].valid;
   assign step_ok = !cell_q[0].valid || !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         emit_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         emit_ff      <= emit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      new_entry_ff <= new_entry_in;
      rsp_item_ff  <= rsp_item_in;
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      emit_in      = emit_ff;
      new_entry_in = new_entry_ff;
      rsp_item_in  = rsp_item_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               step_in = '0;
               emit_in = '0;
               if (req_item.req_type == REQ_LIST) begin
                  state_in = ST_LIST;
               end else begin
                  state_in            = ST_LOAD;
                  new_entry_in.valid  = 1'b1;
                  new_entry_in.key    = req_item.address_key;
                  new_entry_in.stake  = req_item.stake;
                  new_entry_in.score  = req_item.work_score;
                  new_entry_in.weight = weight_of(req_item.stake, req_item.work_score);
               end
            end
         end
         ST_LOAD: state_in = ST_SORT;
         ST_SORT: begin
            step_in = step_ff + CNT_W'(1);
            if (step_ff == LAST_STEP) begin
               state_in = ST_DROP;
            end
         end
         ST_DROP: state_in = ST_IDLE;
         ST_LIST: begin
            if (step_ok) begin
               step_in = step_ff + CNT_W'(1);
               if (emit) begin
                  rsp_valid_in             = 1'b1;
                  rsp_item_in.rank         = RANK_W'(emit_ff);
                  rsp_item_in.entry_key    = cell_q[0].key;
                  rsp_item_in.entry_stake  = cell_q[0].stake;
                  rsp_item_in.entry_score  = cell_q[0].score;
                  rsp_item_in.last         = (emit_ff == LAST_ITEM);
                  emit_in                  = emit_ff + CNT_W'(1);
               end
               if (step_ff == LAST_STEP) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   for (genvar i = 0; i < CELL_COUNT; i++) begin : g_cell
      localparam int LEFT_I    = (i + CELL_COUNT - 1) % CELL_COUNT;
      localparam int RIGHT_I   = (i + 1) % CELL_COUNT;
      localparam bit PARITY    = (i % 2) == 1;
      localparam bit HAS_RIGHT = (i + 1) < CELL_COUNT;
      localparam bit HAS_LEFT  = i > 0;
      localparam bit IS_TABLE  = i < TOP_COUNT;

      always_comb begin
         cell_op[i] = OP_HOLD;
         case (state_ff)
            ST_LOAD: begin
               if (IS_TABLE) begin
                  cell_op[i] = OP_LOAD;
               end else if (!any_hit) begin
                  cell_op[i] = OP_INSERT;
               end
            end
            ST_SORT: begin
               // Pairs start at even cells on even passes, odd cells on odd passes.
               if ((step_ff[0] == PARITY) && HAS_RIGHT) begin
                  cell_op[i] = OP_PAIR_LEFT;
               end else if ((step_ff[0] != PARITY) && HAS_LEFT) begin
                  cell_op[i] = OP_PAIR_RIGHT;
               end
            end
            ST_DROP: begin
               if (!IS_TABLE) begin
                  cell_op[i] = OP_DROP;
               end
            end
            ST_LIST: begin
               if (step_ok) begin
                  cell_op[i] = OP_SHIFT;
               end
            end
            default: cell_op[i] = OP_HOLD;
         endcase
      end

      wtk_cell #(
         .SEED_INDEX (i),
         .SEED_VALID (IS_TABLE)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .op          (cell_op[i]),
         .new_entry   (new_entry_ff),
         .left_entry  (cell_q[LEFT_I]),
         .right_entry (cell_q[RIGHT_I]),
         .right_gt    (gt_vec[RIGHT_I]),
         .entry       (cell_q[i]),
         .gt          (gt_vec[i]),
         .hit         (hit_vec[i])
      );
   end

endmodule

`default_nettype wire
